// ===== src/pspm_pkg.sv =====
// Shared constants and types for the pedal sensor plausibility monitor.
package pspm_pkg;

	localparam int SENSOR_BITS_DEFAULT = 10;
	localparam int TORQUE_BITS         = 15;
	localparam int PERSIST_BITS        = 16;
	localparam int THROTTLE_BITS       = 16;
	localparam int TIME_BITS           = 32;
	localparam int CFG_DATA_BITS       = 16;
	localparam int CFG_INDEX_BITS      = 3;
	localparam int RANGE_MARGIN        = 15;
	localparam int DIV_RADIX_STEPS     = 2;

	localparam logic [TORQUE_BITS-1:0]  TORQUE_RESET  = 15'd32767;
	localparam logic [PERSIST_BITS-1:0] PERSIST_RESET = 16'd100;

	// result bit positions
	localparam int OUT_RANGE       = 0;
	localparam int OUT_DEVIATION   = 1;
	localparam int OUT_JUMP        = 2;
	localparam int OUT_IMPLAUSIBLE = 3;
	localparam int OUT_STOP        = 4;
	localparam int OUT_BITS        = 5;
	localparam int OUT_TDATA_BITS  = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_SENSOR_A_MIN = 3'd0,
		REG_SENSOR_A_MAX = 3'd1,
		REG_SENSOR_B_MIN = 3'd2,
		REG_SENSOR_B_MAX = 3'd3,
		REG_TORQUE_LIMIT = 3'd4,
		REG_PERSIST_TIME = 3'd5
	} cfg_reg_t;

endpackage

// ===== src/pedal_sensor_plausibility_monitor.sv =====
// Top level of the pedal sensor plausibility monitor: registers, sequencer, checks.
//
// One request on s_axis carries two pedal readings, a throttle command and a
// millisecond timestamp; one result per request leaves on m_axis with the
// range, deviation and jump fault flags, their OR and the latched stop flag.
// Registers are written through cfg_we/cfg_index/cfg_data; indexes past the
// register list are ignored. The user must write them only while the block is
// idle; the block itself does not enforce this.
//
// Each sensor mapping takes a multiply step, a divider start, the divider
// iterations at two quotient bits per cycle and the capture of the quotient;
// an evaluation step follows the second mapping.
// s_axis_tready is high only while no request is in work, so a new request is
// taken only once the previous one has left the evaluation step.
//
// The result sits in an output register; a new request is accepted while it
// waits, and the final evaluation step holds until the receiver has taken the
// previous result, so a stalled receiver stalls the block without loss.
// Reset clears the configuration registers to their reset values, clears the
// throttle history and the persistence state, and drops the stop latch.
module pedal_sensor_plausibility_monitor import pspm_pkg::*; #(
	parameter int SENSOR_BITS = SENSOR_BITS_DEFAULT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	// sensor_a, sensor_b, throttle_cmd, now_ms (from bit 0 up), zero padded
	input  logic [((2*SENSOR_BITS+THROTTLE_BITS+TIME_BITS+7)/8)*8-1:0] s_axis_tdata,
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	// range_fault, deviation_fault, jump_fault, implausible_now, stop_engine
	output logic [OUT_TDATA_BITS-1:0] m_axis_tdata
);

	localparam int NUM_BITS    = SENSOR_BITS + TORQUE_BITS;
	localparam int MAP_BITS    = NUM_BITS + 1;
	localparam int DIFF_BITS   = MAP_BITS + 1;
	localparam int SCALED_BITS = DIFF_BITS + 3;
	localparam int JUMP_BITS   = THROTTLE_BITS + 1;
	localparam int B_LSB       = SENSOR_BITS;
	localparam int T_LSB       = 2 * SENSOR_BITS;
	localparam int N_LSB       = T_LSB + THROTTLE_BITS;

	typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_EVAL} state_t;

	state_t state_q;
	logic   sel_b_q;
	logic   div_start_q;

	logic [SENSOR_BITS-1:0]  a_min_q, a_max_q, b_min_q, b_max_q;
	logic [TORQUE_BITS-1:0]  torque_q;
	logic [PERSIST_BITS-1:0] persist_q;

	logic [SENSOR_BITS-1:0]         a_q, b_q;
	logic signed [THROTTLE_BITS-1:0] thr_q;
	logic [TIME_BITS-1:0]           now_q;

	logic signed [THROTTLE_BITS-1:0] last_thr_q;
	logic                            fault_active_q;
	logic [TIME_BITS-1:0]            fault_start_q;
	logic                            stop_latched_q;

	logic [NUM_BITS-1:0]    num_q;
	logic [SENSOR_BITS-1:0] den_q;
	logic                   neg_q;
	logic                   zero_q;
	logic signed [MAP_BITS-1:0] ma_q, mb_q;

	logic                out_valid_q;
	logic [OUT_BITS-1:0] out_data_q;

	logic [NUM_BITS-1:0] div_quot;
	logic                div_done;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_min_q   <= '0;
			a_max_q   <= '1;
			b_min_q   <= '0;
			b_max_q   <= '1;
			torque_q  <= TORQUE_RESET;
			persist_q <= PERSIST_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_SENSOR_A_MIN: a_min_q   <= cfg_data[SENSOR_BITS-1:0];
				REG_SENSOR_A_MAX: a_max_q   <= cfg_data[SENSOR_BITS-1:0];
				REG_SENSOR_B_MIN: b_min_q   <= cfg_data[SENSOR_BITS-1:0];
				REG_SENSOR_B_MAX: b_max_q   <= cfg_data[SENSOR_BITS-1:0];
				REG_TORQUE_LIMIT: torque_q  <= cfg_data[TORQUE_BITS-1:0];
				REG_PERSIST_TIME: persist_q <= cfg_data[PERSIST_BITS-1:0];
				default: ;
			endcase
		end
	end

	// shared multiply: |x - lo| * torque, plus divisor magnitude and sign
	logic [SENSOR_BITS-1:0]        mx, mlo, mhi;
	logic signed [SENSOR_BITS:0]   dx, span;
	logic [SENSOR_BITS:0]          dx_mag, span_mag;
	logic [NUM_BITS-1:0]           prod;

	always_comb begin
		mx       = sel_b_q ? b_q : a_q;
		mlo      = sel_b_q ? b_min_q : a_min_q;
		mhi      = sel_b_q ? b_max_q : a_max_q;
		dx       = $signed({1'b0, mx}) - $signed({1'b0, mlo});
		span     = $signed({1'b0, mhi}) - $signed({1'b0, mlo});
		dx_mag   = dx[SENSOR_BITS] ? -dx : dx;
		span_mag = span[SENSOR_BITS] ? -span : span;
		prod     = NUM_BITS'(dx_mag[SENSOR_BITS-1:0]) * NUM_BITS'(torque_q);
	end

	pspm_divider #(
		.NUM_BITS(NUM_BITS),
		.DEN_BITS(SENSOR_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start_q),
		.num   (num_q),
		.den   (den_q),
		.quot  (div_quot),
		.done  (div_done)
	);

	// signed mapped value from the divider result
	logic signed [MAP_BITS-1:0] map_v;
	always_comb begin
		if (zero_q)
			map_v = '0;
		else if (neg_q)
			map_v = -$signed({1'b0, div_quot});
		else
			map_v = $signed({1'b0, div_quot});
	end

	// final checks
	logic signed [DIFF_BITS-1:0] dev_diff;
	logic [DIFF_BITS-1:0]        dev_mag;
	logic [SCALED_BITS-1:0]      dev_scaled;
	logic                        dev_f;
	logic                        range_f;
	logic signed [JUMP_BITS-1:0] jump_diff;
	logic [JUMP_BITS-1:0]        jump_mag;
	logic                        jump_f;
	logic                        bad;
	logic [TIME_BITS-1:0]        elapsed;

	always_comb begin
		dev_diff   = DIFF_BITS'(ma_q) - DIFF_BITS'(mb_q);
		dev_mag    = dev_diff[DIFF_BITS-1] ? -dev_diff : dev_diff;
		dev_scaled = (SCALED_BITS'(dev_mag) << 3) + (SCALED_BITS'(dev_mag) << 1);
		dev_f      = dev_scaled >= SCALED_BITS'(torque_q);
		// compare against margin-widened window without going negative
		range_f = ({1'b0, a_q} > ({1'b0, a_max_q} + (SENSOR_BITS+1)'(RANGE_MARGIN))) ||
		          (({1'b0, a_q} + (SENSOR_BITS+1)'(RANGE_MARGIN)) < {1'b0, a_min_q}) ||
		          ({1'b0, b_q} > ({1'b0, b_max_q} + (SENSOR_BITS+1)'(RANGE_MARGIN))) ||
		          (({1'b0, b_q} + (SENSOR_BITS+1)'(RANGE_MARGIN)) < {1'b0, b_min_q});
		jump_diff = JUMP_BITS'(thr_q) - JUMP_BITS'(last_thr_q);
		jump_mag  = jump_diff[JUMP_BITS-1] ? -jump_diff : jump_diff;
		jump_f    = jump_mag >= JUMP_BITS'(torque_q);
		bad       = range_f || dev_f || jump_f;
		elapsed   = now_q - fault_start_q;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			sel_b_q        <= 1'b0;
			div_start_q    <= 1'b0;
			last_thr_q     <= '0;
			fault_active_q <= 1'b0;
			fault_start_q  <= '0;
			stop_latched_q <= 1'b0;
			out_valid_q    <= 1'b0;
			out_data_q     <= '0;
		end else begin
			div_start_q <= 1'b0;
			if (out_valid_q && m_axis_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						sel_b_q <= 1'b0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					div_start_q <= 1'b1;
					state_q     <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						if (sel_b_q) begin
							state_q <= S_EVAL;
						end else begin
							sel_b_q <= 1'b1;
							state_q <= S_MUL;
						end
					end
				end
				S_EVAL: begin
					// hold until the output register is free
					if (!out_valid_q || m_axis_tready) begin
						last_thr_q <= thr_q;
						if (!bad) begin
							fault_active_q <= 1'b0;
						end else if (fault_active_q) begin
							if (elapsed > TIME_BITS'(persist_q))
								stop_latched_q <= 1'b1;
						end else begin
							fault_active_q <= 1'b1;
							fault_start_q  <= now_q;
						end
						out_data_q[OUT_RANGE]       <= range_f;
						out_data_q[OUT_DEVIATION]   <= dev_f;
						out_data_q[OUT_JUMP]        <= jump_f;
						out_data_q[OUT_IMPLAUSIBLE] <= bad;
						out_data_q[OUT_STOP]        <= stop_latched_q || (bad &&
							fault_active_q && (elapsed > TIME_BITS'(persist_q)));
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			a_q   <= s_axis_tdata[B_LSB-1:0];
			b_q   <= s_axis_tdata[T_LSB-1:B_LSB];
			thr_q <= s_axis_tdata[N_LSB-1:T_LSB];
			now_q <= s_axis_tdata[N_LSB+TIME_BITS-1:N_LSB];
		end
		if (state_q == S_MUL) begin
			num_q  <= prod;
			den_q  <= span_mag[SENSOR_BITS-1:0];
			neg_q  <= dx[SENSOR_BITS] ^ span[SENSOR_BITS];
			zero_q <= (span == '0);
		end
		if (state_q == S_DIV && div_done) begin
			if (sel_b_q)
				mb_q <= map_v;
			else
				ma_q <= map_v;
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_TDATA_BITS'(out_data_q);

	a_stop_holds: assert property (@(posedge clk) disable iff (!arst_n)
		stop_latched_q |=> stop_latched_q)
		else $error("stop latch dropped without reset");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> (state_q == S_MUL && !sel_b_q))
		else $error("accepted request did not start with first sensor");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider finished outside the divide state");

	a_stop_needs_fault: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_data_q[OUT_STOP]) |-> out_data_q[OUT_IMPLAUSIBLE])
		else $error("stop raised on a clean result");

endmodule

// ===== src/pspm_divider.sv =====
// Shared iterative restoring divider, two quotient bits per cycle.
module pspm_divider import pspm_pkg::*; #(
	parameter int NUM_BITS = SENSOR_BITS_DEFAULT + TORQUE_BITS,
	parameter int DEN_BITS = SENSOR_BITS_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [NUM_BITS-1:0] num,
	input  logic [DEN_BITS-1:0] den,
	output logic [NUM_BITS-1:0] quot,
	output logic                done
);

	localparam int STEPS     = DIV_RADIX_STEPS;
	localparam int WORK_BITS = ((NUM_BITS + STEPS - 1) / STEPS) * STEPS;
	localparam int ITERS     = WORK_BITS / STEPS;
	localparam int CNT_BITS  = $clog2(ITERS + 1);

	logic [WORK_BITS-1:0] work_q, work_d;
	logic [DEN_BITS-1:0]  rem_q, rem_d;
	logic [CNT_BITS-1:0]  cnt_q;
	logic                 busy_q;
	logic                 done_q;

	always_comb begin
		logic [DEN_BITS:0] trial;
		work_d = work_q;
		rem_d  = rem_q;
		for (int i = 0; i < STEPS; i++) begin
			trial  = {rem_d, work_d[WORK_BITS-1]};
			work_d = {work_d[WORK_BITS-2:0], 1'b0};
			if (trial >= {1'b0, den}) begin
				rem_d     = DEN_BITS'(trial - {1'b0, den});
				work_d[0] = 1'b1;
			end else begin
				rem_d = trial[DEN_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(ITERS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= WORK_BITS'(num);
			rem_q  <= '0;
		end else if (busy_q) begin
			work_q <= work_d;
			rem_q  <= rem_d;
		end
	end

	assign quot = work_q[NUM_BITS-1:0];
	assign done = done_q;

endmodule
